// ===== rtl/heq_pkg.sv =====
// Package: shared widths, mode codes and controller command types.
package heq_pkg;
  localparam int unsigned CountWidth = 25;
  localparam int unsigned Bins       = 256;
  localparam int unsigned BinWidth   = 8;
  localparam logic [CountWidth-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    MODE_COUNT = 2'd0,
    MODE_REMAP = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CLEAR = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [1:0] channel;
    logic [7:0] bin;
  } in_word_t;

  typedef struct packed {
    logic [7:0]            out_red;
    logic [7:0]            out_green;
    logic [7:0]            out_blue;
    logic [CountWidth-1:0] bin_count;
  } out_word_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic load;        // capture input word, start luma products
    logic clr_step;    // clear one luma and three output bins at idx_i
    logic hist_rd;     // read luma bin for count
    logic hist_wr;     // write incremented luma bin
    logic bld_rd;      // read luma bin at build index
    logic bld_div;     // start map division
    logic bld_wr;      // write map entry
    logic map_rd;      // read map at y
    logic div_start;   // start channel division (sel by div_ch)
    logic [1:0] div_ch;
    logic oh_rd;       // take finished quotient as result of channel div_ch
    logic oh_wr;       // write out hist bin
    logic rb_rd;       // readback read
    logic out_load_px;
    logic out_load_rb;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic y_zero;
  } sts_t;
endpackage

// ===== rtl/heq_if.sv =====
// Valid/ready stream interface carrying one word.
interface heq_if #(parameter type T = logic) (input logic clk_i);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/heq_ram.sv =====
// Generic single-port RAM with registered read.
module heq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

// ===== rtl/heq_div.sv =====
// Restoring divider, one quotient bit a cycle, 34-bit dividend / 26-bit divisor.
module heq_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [33:0] num_i,
  input  logic [25:0] den_i,
  output logic        done_o,
  output logic [33:0] quo_o
);
  logic [33:0] quo_q, quo_d;
  logic [26:0] rem_q, rem_d;
  logic [25:0] den_q;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [26:0] trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      cnt_d  = 6'd34;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q[25:0], quo_q[33]};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[32:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[32:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

// ===== rtl/heq_datapath.sv =====
// Datapath: histogram and map memories, luma arithmetic, shared divider, output word.
module heq_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  heq_pkg::cmd_t        cmd_i,
  output heq_pkg::sts_t        sts_o,
  input  heq_pkg::in_word_t    word_i,
  input  logic [7:0]           idx_i,
  input  logic [24:0]          total_i,
  output heq_pkg::out_word_t   out_o
);
  import heq_pkg::*;

  in_word_t w_q;
  logic [17:0] luma_sum_q;
  logic [15:0] y_sum_q;
  logic [7:0]  luma, y;
  logic [24:0] run_q, run_d;
  logic [7:0]  nch_q [3];
  out_word_t   out_q;

  // RAM ports
  logic        lh_we, mp_we;
  logic [7:0]  lh_addr, mp_addr;
  logic [24:0] lh_wd, lh_rd;
  logic [7:0]  mp_wd, mp_rd;
  logic        oh_we [3];
  logic [7:0]  oh_addr [3];
  logic [24:0] oh_wd [3], oh_rdat [3];

  logic        dv_start;
  logic [33:0] dv_num, dv_quo;
  logic [25:0] dv_den;
  logic        dv_done;
  logic [7:0]  sat_q;
  logic [7:0]  quo_sat;
  logic [7:0]  ch_val;
  logic [25:0] sum26;

  // luma: floor(s/1000) and y: floor(s/100), s < 2^18 / 2^15; reciprocal + fixup
  always_comb begin
    logic [35:0] p;
    logic [17:0] r;
    logic [31:0] q;
    logic [15:0] ry;
    p = (luma_sum_q * 36'd268436) >> 28;
    r = luma_sum_q - 18'(p[7:0] * 10'd1000);
    luma = (r >= 18'd1000) ? p[7:0] + 8'd1 : p[7:0];
    q = (y_sum_q * 32'd41944) >> 22;
    ry = y_sum_q - 16'(q[8:0] * 7'd100);
    q = (ry >= 16'd100) ? q + 32'd1 : q;
    y = (q[8:0] > 9'd255) ? 8'd255 : q[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      w_q        <= word_i;
      luma_sum_q <= 18'(word_i.red * 10'd299) + 18'(word_i.green * 10'd587)
                  + 18'(word_i.blue * 10'd114);
      y_sum_q    <= 16'(word_i.red * 5'd30) + 16'(word_i.green * 6'd59)
                  + 16'(word_i.blue * 4'd11) + 16'd50;
    end
  end

  assign sts_o.y_zero   = (y == 8'd0);
  assign sts_o.div_done = dv_done;

  // luma histogram
  always_comb begin
    lh_we   = 1'b0;
    lh_addr = luma;
    lh_wd   = '0;
    if (cmd_i.clr_step) begin
      lh_we = 1'b1; lh_addr = idx_i; lh_wd = '0;
    end else if (cmd_i.bld_rd) begin
      lh_addr = idx_i;
    end else if (cmd_i.hist_wr) begin
      lh_we = 1'b1;
      lh_wd = (lh_rd == CountMax) ? lh_rd : lh_rd + 25'd1;
    end
  end
  heq_ram #(.Width(25), .Depth(256)) u_luma (
    .clk_i, .we_i(lh_we), .addr_i(lh_addr), .wdata_i(lh_wd), .rdata_o(lh_rd));

  // running sum saturates
  assign sum26 = {1'b0, run_q} + {1'b0, lh_rd};
  always_comb begin
    run_d = run_q;
    if (cmd_i.clr_step && idx_i == 8'd0) run_d = '0;
    else if (cmd_i.bld_div) run_d = sum26[25] ? CountMax : sum26[24:0];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) run_q <= '0;
    else         run_q <= run_d;
  end

  // map table
  assign mp_we   = cmd_i.bld_wr;
  assign mp_addr = cmd_i.bld_wr ? idx_i : y;
  assign mp_wd   = sat_q;
  heq_ram #(.Width(8), .Depth(256)) u_map (
    .clk_i, .we_i(mp_we), .addr_i(mp_addr), .wdata_i(mp_wd), .rdata_o(mp_rd));

  // shared divider: build uses (510*sum+d)/(2d); remap (2*c*m+y)/(2y)
  always_comb begin
    logic [24:0] d;
    d = (total_i == '0) ? 25'd1 : total_i;
    unique case (cmd_i.div_ch)
      2'd0:    ch_val = w_q.red;
      2'd1:    ch_val = w_q.green;
      default: ch_val = w_q.blue;
    endcase
    dv_start = cmd_i.bld_div | cmd_i.div_start;
    if (cmd_i.bld_div) begin
      dv_num = 34'(run_d * 9'd510) + 34'(d);
      dv_den = {d, 1'b0};
    end else begin
      dv_num = 34'({ch_val, 1'b0} * mp_rd) + 34'(y);
      dv_den = 26'({y, 1'b0});
    end
  end
  heq_div u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quo_o(dv_quo));

  assign quo_sat = (dv_quo > 34'd255) ? 8'd255 : dv_quo[7:0];

  always_ff @(posedge clk_i) begin
    if (dv_done) sat_q <= quo_sat;
  end

  // output channel results, taken straight from the finished quotient
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      nch_q[0] <= '0; nch_q[1] <= '0; nch_q[2] <= '0;
    end else if (cmd_i.oh_rd && !sts_o.y_zero) begin
      nch_q[cmd_i.div_ch] <= quo_sat;
    end
  end

  // output histograms, one RAM per channel
  for (genvar c = 0; c < 3; c++) begin : g_oh
    always_comb begin
      oh_we[c]   = 1'b0;
      oh_wd[c]   = '0;
      oh_addr[c] = nch_q[c];
      if (cmd_i.clr_step) begin
        oh_we[c] = 1'b1; oh_addr[c] = idx_i;
      end else if (cmd_i.rb_rd) begin
        oh_addr[c] = w_q.bin;
      end else if (cmd_i.oh_wr) begin
        oh_we[c] = 1'b1;
        oh_wd[c] = (oh_rdat[c] == CountMax) ? oh_rdat[c] : oh_rdat[c] + 25'd1;
      end
    end
    heq_ram #(.Width(25), .Depth(256)) u_oh (
      .clk_i, .we_i(oh_we[c]), .addr_i(oh_addr[c]), .wdata_i(oh_wd[c]),
      .rdata_o(oh_rdat[c]));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load_px) begin
      out_q <= '{out_red: nch_q[0], out_green: nch_q[1], out_blue: nch_q[2],
                 bin_count: '0};
    end else if (cmd_i.out_load_rb) begin
      out_q.out_red   <= '0;
      out_q.out_green <= '0;
      out_q.out_blue  <= '0;
      unique case (w_q.channel)
        2'd0:    out_q.bin_count <= oh_rdat[0];
        2'd1:    out_q.bin_count <= oh_rdat[1];
        2'd2:    out_q.bin_count <= oh_rdat[2];
        default: out_q.bin_count <= '0;
      endcase
    end
  end
  assign out_o = out_q;
endmodule

// ===== rtl/heq_ctrl.sv =====
// Controller: sequences clear sweep, count, table build, remap and readback.
module heq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  heq_pkg::sts_t      sts_i,
  output heq_pkg::cmd_t      cmd_o,
  output logic [7:0]         idx_o
);
  import heq_pkg::*;

  typedef enum logic [11:0] {
    S_CLR   = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_CNT   = 12'b000000000100,
    S_CNTW  = 12'b000000001000,
    S_BRD   = 12'b000000010000,
    S_BDIV  = 12'b000000100000,
    S_BWR   = 12'b000001000000,
    S_MAP   = 12'b000010000000,
    S_PDIV  = 12'b000100000000,
    S_OHR   = 12'b001000000000,
    S_OHW   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  logic [7:0] idx_q, idx_d;
  logic [1:0] ch_q, ch_d;
  logic built_q, built_d;
  logic ov_q, ov_d;
  logic busy_div_q, busy_div_d;
  logic rb_q, rb_d;

  assign in_ready_o  = (state_q == S_IDLE) && !ov_q && !rb_q;
  assign out_valid_o = ov_q;
  assign idx_o       = idx_q;

  always_comb begin
    logic acc;
    acc        = in_valid_i && in_ready_o;
    state_d    = state_q;
    idx_d      = idx_q;
    ch_d       = ch_q;
    built_d    = built_q;
    busy_div_d = busy_div_q;
    rb_d       = 1'b0;
    ov_d       = ov_q && !out_ready_i;
    cmd_o      = '0;
    cmd_o.div_ch = ch_q;
    unique case (state_q)
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        idx_d = idx_q + 8'd1;
        if (idx_q == 8'd255) begin
          state_d = S_IDLE;
          built_d = 1'b0;
        end
      end
      S_IDLE: begin
        if (rb_q) begin
          cmd_o.out_load_rb = 1'b1;
          ov_d = 1'b1;
        end else if (acc) begin
          cmd_o.load = 1'b1;
          unique case (mode_i)
            MODE_COUNT: state_d = S_CNT;
            MODE_REMAP: begin
              state_d = built_q ? S_MAP : S_BRD;
              idx_d   = '0;
            end
            MODE_READ:  state_d = S_OUT;
            default: begin
              state_d = S_CLR;
              idx_d   = '0;
            end
          endcase
        end
      end
      S_CNT: begin
        cmd_o.hist_rd = 1'b1;
        state_d = S_CNTW;
      end
      S_CNTW: begin
        cmd_o.hist_wr = 1'b1;
        state_d = S_IDLE;
      end
      S_BRD: begin
        cmd_o.bld_rd = 1'b1;
        state_d = S_BDIV;
      end
      S_BDIV: begin
        if (!busy_div_q) begin
          cmd_o.bld_div = 1'b1;
          busy_div_d = 1'b1;
        end else if (sts_i.div_done) begin
          busy_div_d = 1'b0;
          state_d = S_BWR;
        end
      end
      S_BWR: begin
        cmd_o.bld_wr = 1'b1;
        idx_d = idx_q + 8'd1;
        if (idx_q == 8'd255) begin
          built_d = 1'b1;
          state_d = S_MAP;
        end else begin
          state_d = S_BRD;
        end
      end
      S_MAP: begin
        cmd_o.map_rd = 1'b1;
        ch_d = 2'd0;
        state_d = S_PDIV;
      end
      S_PDIV: begin
        if (sts_i.y_zero) begin
          state_d = S_OHR;
        end else if (!busy_div_q) begin
          cmd_o.div_start = 1'b1;
          busy_div_d = 1'b1;
        end else if (sts_i.div_done) begin
          cmd_o.oh_rd = 1'b1;
          busy_div_d = 1'b0;
          ch_d = ch_q + 2'd1;
          state_d = (ch_q == 2'd2) ? S_OHR : S_PDIV;
        end
      end
      S_OHR: begin
        // out histograms read at the final channel values
        state_d = S_OHW;
      end
      S_OHW: begin
        cmd_o.oh_wr = 1'b1;
        cmd_o.out_load_px = 1'b1;
        ov_d = 1'b1;
        state_d = S_IDLE;
      end
      S_OUT: begin
        cmd_o.rb_rd = 1'b1;
        rb_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLR;
      idx_q      <= '0;
      ch_q       <= '0;
      built_q    <= 1'b0;
      ov_q       <= 1'b0;
      busy_div_q <= 1'b0;
      rb_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      ch_q       <= ch_d;
      built_q    <= built_d;
      ov_q       <= ov_d;
      busy_div_q <= busy_div_d;
      rb_q       <= rb_d;
    end
  end
endmodule

// ===== rtl/histogram_equalize_rgb_by_luma_core.sv =====
// The first remap word after reset or a clear word builds the map table; for
// black pixels (y = 0) the channel divisions are skipped.
// One word is in flight at a time; the shared restoring divider paces remap words.
// After reset and after a clear word, a sweep zeroes all 256 bins of the
// histograms while input is held off; total_q resets to 1 on reset only.
module histogram_equalize_rgb_by_luma_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [24:0]  cfg_wdata_i,
  heq_if.sink          in_if,
  heq_if.source        out_if
);
  import heq_pkg::*;

  logic [24:0] total_q;
  cmd_t        cmd;
  sts_t        sts;
  logic [7:0]  idx;
  in_word_t    word;
  out_word_t   res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)       total_q <= 25'd1;
    else if (cfg_we_i) total_q <= cfg_wdata_i;
  end

  assign word = in_if.data;

  heq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .mode_i(word.mode),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .cmd_o(cmd), .idx_o(idx));

  heq_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .word_i(word), .idx_i(idx),
    .total_i(total_q), .out_o(res));

  assign out_if.data = res;
endmodule
